// File: hdl/ihex_pkg.sv
package ihex_pkg;

	typedef enum logic [3:0] {
		KIND_DATA      = 4'd0,
		KIND_OK        = 4'd1,
		KIND_SKIP      = 4'd2,
		KIND_END       = 4'd3,
		KIND_SUM       = 4'd4,
		KIND_OFFSET    = 4'd5,
		KIND_LENGTH    = 4'd6,
		KIND_FORMAT    = 4'd7,
		KIND_INPUT_END = 4'd8
	} kind_t;

	typedef enum logic {
		PH_IDLE   = 1'b0,
		PH_RECORD = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		FIN_RUN       = 2'd0,
		FIN_END       = 2'd1,
		FIN_ERR       = 2'd2,
		FIN_INPUT_END = 2'd3
	} fin_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;

	// everything one input item produces, in emission order data, status, input end
	typedef struct packed {
		logic        data_v;
		logic [15:0] data_addr;
		logic [7:0]  data_byte;
		logic        stat_v;
		kind_t       stat_kind;
		logic [15:0] stat_addr;
		logic [7:0]  stat_type;
		logic        end_v;
	} bundle_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic [7:0]  record_type;
	} result_t;

endpackage

// File: hdl/ihex_front.sv
module ihex_front import ihex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] char_in,
	input  logic       end_of_file,
	output bundle_t    bnd
);

	phase_t      phase_q, n_phase;
	fin_t        fin_q, n_fin;
	logic [3:0]  hi_q, n_hi;
	logic        pend_q, n_pend;
	logic [8:0]  cnt_q, n_cnt;
	logic [7:0]  sum_q, n_sum;
	logic [7:0]  size_q, n_size;
	logic [15:0] off_q, n_off;
	logic [7:0]  rkind_q, n_rkind;
	logic [16:0] exp_q, n_exp;

	logic       dig_ok;
	logic [3:0] dig_val;
	logic [7:0] byte_val;
	logic       is_eol;
	kind_t      close_kind;

	always_comb begin
		dig_ok  = 1'b1;
		dig_val = 4'd0;
		if (char_in inside {["0":"9"]}) begin
			dig_val = 4'(char_in - 8'h30);
		end else if (char_in inside {["A":"F"]}) begin
			dig_val = 4'(char_in - 8'h37);
		end else if (char_in inside {["a":"f"]}) begin
			dig_val = 4'(char_in - 8'h57);
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign is_eol   = (char_in == CH_CR) || (char_in == CH_LF);
	assign byte_val = {hi_q, dig_val};

	always_comb begin
		n_phase = phase_q;
		n_fin   = fin_q;
		n_hi    = hi_q;
		n_pend  = pend_q;
		n_cnt   = cnt_q;
		n_sum   = sum_q;
		n_size  = size_q;
		n_off   = off_q;
		n_rkind = rkind_q;
		n_exp   = exp_q;
		bnd     = '0;
		bnd.stat_kind = KIND_FORMAT;
		close_kind    = KIND_OK;
		if (acc) begin
			if (fin_q == FIN_RUN) begin
				if (is_eol) begin
					// closing is handled below together with end of file
				end else if (phase_q == PH_IDLE) begin
					if (char_in == CH_COLON) begin
						n_phase = PH_RECORD;
						n_hi    = 4'd0;
						n_pend  = 1'b0;
						n_cnt   = 9'd0;
						n_sum   = 8'd0;
						n_size  = 8'd0;
						n_off   = 16'd0;
						n_rkind = 8'd0;
					end else begin
						bnd.stat_v = 1'b1;
						n_fin      = FIN_ERR;
					end
				end else if (!dig_ok) begin
					bnd.stat_v    = 1'b1;
					bnd.stat_addr = off_q;
					bnd.stat_type = rkind_q;
					n_fin         = FIN_ERR;
					n_phase       = PH_IDLE;
					n_pend        = 1'b0;
				end else if (pend_q) begin
					n_pend = 1'b0;
					n_sum  = sum_q + byte_val;
					case (cnt_q)
						9'd0: n_size = byte_val;
						9'd1: n_off  = {byte_val, 8'd0};
						9'd2: n_off  = {off_q[15:8], byte_val};
						9'd3: n_rkind = byte_val;
						default: begin
							if (rkind_q == REC_DATA &&
								{1'b0, cnt_q} < ({2'b0, size_q} + 10'd4)) begin
								bnd.data_v    = 1'b1;
								bnd.data_addr = off_q + {7'b0, cnt_q} - 16'd4;
								bnd.data_byte = byte_val;
							end
						end
					endcase
					if (cnt_q != 9'h1FF) begin
						n_cnt = cnt_q + 9'd1;
					end
				end else begin
					n_hi   = dig_val;
					n_pend = 1'b1;
				end

				if ((is_eol || end_of_file) && n_fin == FIN_RUN && n_phase == PH_RECORD) begin
					if (n_pend) begin
						close_kind = KIND_FORMAT;
					end else if (n_sum != 8'd0) begin
						close_kind = KIND_SUM;
					end else if (n_cnt < 9'd5) begin
						close_kind = KIND_LENGTH;
					end else if (n_rkind == REC_EOF) begin
						close_kind = KIND_END;
					end else if (n_rkind != REC_DATA) begin
						close_kind = KIND_SKIP;
					end else if ({1'b0, n_off} != exp_q) begin
						close_kind = KIND_OFFSET;
					end else if ({1'b0, n_cnt} < ({2'b0, n_size} + 10'd5)) begin
						close_kind = KIND_LENGTH;
					end else begin
						close_kind = KIND_OK;
					end
					bnd.stat_v    = 1'b1;
					bnd.stat_kind = close_kind;
					bnd.stat_addr = n_off;
					bnd.stat_type = n_rkind;
					n_phase       = PH_IDLE;
					n_pend        = 1'b0;
					if (close_kind == KIND_END) begin
						n_fin = FIN_END;
					end else if (close_kind == KIND_OK) begin
						n_exp = {1'b0, n_off} + {9'b0, n_size};
					end else if (close_kind != KIND_SKIP) begin
						n_fin = FIN_ERR;
					end
				end
			end

			if (end_of_file) begin
				bnd.end_v = 1'b1;
				if (n_fin == FIN_RUN) begin
					n_fin = FIN_INPUT_END;
				end
				n_phase = PH_IDLE;
				n_pend  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fin_q   <= FIN_RUN;
			hi_q    <= 4'd0;
			pend_q  <= 1'b0;
			cnt_q   <= 9'd0;
			sum_q   <= 8'd0;
			size_q  <= 8'd0;
			off_q   <= 16'd0;
			rkind_q <= 8'd0;
			exp_q   <= 17'd0;
		end else begin
			phase_q <= n_phase;
			fin_q   <= n_fin;
			hi_q    <= n_hi;
			pend_q  <= n_pend;
			cnt_q   <= n_cnt;
			sum_q   <= n_sum;
			size_q  <= n_size;
			off_q   <= n_off;
			rkind_q <= n_rkind;
			exp_q   <= n_exp;
		end
	end

	a_pend_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> phase_q == PH_RECORD)
		else $error("digit pending outside a record");

	a_finished_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q != FIN_RUN |-> phase_q == PH_IDLE)
		else $error("record open after decoding finished");

	a_data_from_data_record: assert property (@(posedge clk) disable iff (!arst_n)
		bnd.data_v |-> rkind_q == REC_DATA)
		else $error("data item from a non-data record");

endmodule

// File: hdl/ihex_queue.sv
module ihex_queue import ihex_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_bnd,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t        mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_bnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

// File: hdl/ihex_back.sv
module ihex_back import ihex_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  logic    empty,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	bundle_t    bnd_q;
	logic [2:0] mask_q;      // end, status, data
	logic [2:0] sel;
	logic [2:0] mask_after;
	logic       out_free;
	logic       take;
	logic       valid_q;
	result_t    res_q;
	result_t    nxt;

	assign out_free = !valid_q || out_ready;
	assign take     = out_free && (mask_q != 3'b000);

	always_comb begin
		sel = 3'b000;
		nxt = '0;
		if (mask_q[0]) begin
			sel             = 3'b001;
			nxt.kind        = KIND_DATA;
			nxt.address     = bnd_q.data_addr;
			nxt.data_byte   = bnd_q.data_byte;
			nxt.record_type = REC_DATA;   // data only comes from type 00 records
		end else if (mask_q[1]) begin
			sel             = 3'b010;
			nxt.kind        = bnd_q.stat_kind;
			nxt.address     = bnd_q.stat_addr;
			nxt.record_type = bnd_q.stat_type;
		end else begin
			sel      = {mask_q[2], 2'b00};
			nxt.kind = KIND_INPUT_END;
		end
	end

	assign mask_after = take ? (mask_q & ~sel) : mask_q;
	assign pop        = !empty && (mask_after == 3'b000);

	always_ff @(posedge clk) begin
		if (pop) begin
			bnd_q <= head;
		end
		if (take) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= 3'b000;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= {head.end_v, head.stat_v, head.data_v};
			end else begin
				mask_q <= mask_after;
			end
			if (take) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

// File: hdl/intel_hex_record_decoder.sv
// channel  dir  tdata                        tuser      tlast
// s_       in   [7:0] char_in                -          end_of_file
// m_       out  [15:0] address, [23:16]      [3:0] kind -
//               data_byte, [31:24] record_type
//
// one character is taken per cycle while the queue has room; its results (up to three) are queued as one entry
// results leave one per cycle while the output is ready, so a character that yields several results
// drains slower than it enters, and the queue of QUEUE_DEPTH entries absorbs such bursts
// the front stalls only when the queue is full; results pass the queue, the back's entry and output registers
// reset clears the decoder to idle between lines with no record and expected offset zero
module intel_hex_record_decoder import ihex_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [15:0] address, [23:16] data_byte, [31:24] record_type
	output logic [3:0]  m_tuser     // [3:0] kind
);

	logic    acc;
	logic    full;
	logic    empty;
	logic    pop;
	logic    push;
	bundle_t bnd;
	bundle_t head;
	result_t res;

	assign s_tready = !full;
	assign acc      = s_tvalid && !full;
	assign push     = acc && (bnd.data_v || bnd.stat_v || bnd.end_v);

	ihex_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.char_in     (s_tdata),
		.end_of_file (s_tlast),
		.bnd         (bnd)
	);

	ihex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_bnd (bnd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.record_type, res.data_byte, res.address};
	assign m_tuser = res.kind;

endmodule

// File: tb/intel_hex_record_decoder_tb.sv
module intel_hex_record_decoder_tb import ihex_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         drain;
	} char_item_t;

	// how the run is brought to its sticky stop, one per run
	typedef enum int {
		STOP_NO_COLON,
		STOP_BAD_DIGIT,
		STOP_ODD_DIGITS,
		STOP_SHORT_HEADER,
		STOP_CHECKSUM,
		STOP_OFFSET,
		STOP_LENGTH,
		STOP_END_RECORD,
		STOP_EOF_OPEN,
		STOP_EOF_TRUNCATED
	} stop_t;

	localparam int QUIET_FROM = 300;
	localparam int QUIET_TO   = 800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;

	char_item_t pending_chars[$];
	result_t    expected_results[$];
	logic       char_taken = 1'b0;
	int         cycle_count = 0;
	int         errors = 0;

	// decoder state mirrored at the block's widths
	phase_t      dec_phase;
	logic [3:0]  dec_hi;
	logic        dec_pend;
	logic [8:0]  dec_count;
	logic [7:0]  dec_sum;
	logic [7:0]  dec_size;
	logic [15:0] dec_off;
	logic [7:0]  dec_type;
	logic [16:0] dec_next;
	fin_t        dec_fin;

	intel_hex_record_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("intel_hex_record_decoder regression: fail");
		$finish;
	end

	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) return 8'("0") + 8'(n);
		// letters in either case
		return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
	endfunction

	task automatic decoder_reset();
		dec_phase = PH_IDLE;
		dec_hi = '0;
		dec_pend = 1'b0;
		dec_count = '0;
		dec_sum = '0;
		dec_size = '0;
		dec_off = '0;
		dec_type = '0;
		dec_next = '0;
		dec_fin = FIN_RUN;
	endtask

	task automatic push_result(input kind_t k, input logic [15:0] a, input logic [7:0] d,
			input logic [7:0] t);
		result_t r;
		r.kind = k;
		r.address = a;
		r.data_byte = d;
		r.record_type = t;
		expected_results.push_back(r);
	endtask

	task automatic take_byte(input logic [7:0] b);
		int idx;
		idx = int'(dec_count);
		dec_sum = dec_sum + b;
		if (idx == 0) dec_size = b;
		else if (idx == 1) dec_off = {b, 8'h00};
		else if (idx == 2) dec_off = {dec_off[15:8], b};
		else if (idx == 3) dec_type = b;
		else if (dec_type == REC_DATA && idx < 4 + int'(dec_size))
			push_result(KIND_DATA, 16'(int'(dec_off) + idx - 4), b, dec_type);
		if (dec_count != 9'h1FF) dec_count = dec_count + 9'd1;
	endtask

	task automatic close_record();
		kind_t k;
		dec_phase = PH_IDLE;
		if (dec_pend) k = KIND_FORMAT;
		else if (dec_sum != 8'h00) k = KIND_SUM;
		else if (dec_count < 9'd5) k = KIND_LENGTH;
		else if (dec_type == REC_EOF) k = KIND_END;
		else if (dec_type != REC_DATA) k = KIND_SKIP;
		else if ({1'b0, dec_off} != dec_next) k = KIND_OFFSET;
		else if (int'(dec_count) < int'(dec_size) + 5) k = KIND_LENGTH;
		else k = KIND_OK;
		if (k == KIND_END) dec_fin = FIN_END;
		else if (k == KIND_OK) dec_next = {1'b0, dec_off} + 17'(dec_size);
		else if (k != KIND_SKIP) dec_fin = FIN_ERR;
		dec_pend = 1'b0;
		push_result(k, dec_off, 8'h00, dec_type);
	endtask

	task automatic predict_char(input logic [7:0] c, input logic eof);
		int v;
		if (dec_fin == FIN_RUN) begin
			if (c == CH_CR || c == CH_LF) begin
				if (dec_phase == PH_RECORD) close_record();
			end else if (dec_phase == PH_IDLE) begin
				if (c == CH_COLON) begin
					dec_phase = PH_RECORD;
					dec_hi = '0;
					dec_pend = 1'b0;
					dec_count = '0;
					dec_sum = '0;
					dec_size = '0;
					dec_off = '0;
					dec_type = '0;
				end else begin
					push_result(KIND_FORMAT, 16'h0000, 8'h00, 8'h00);
					dec_fin = FIN_ERR;
				end
			end else begin
				v = hex_value(c);
				if (v < 0) begin
					push_result(KIND_FORMAT, dec_off, 8'h00, dec_type);
					dec_fin = FIN_ERR;
					dec_phase = PH_IDLE;
					dec_pend = 1'b0;
				end else if (dec_pend) begin
					dec_pend = 1'b0;
					take_byte({dec_hi, 4'(v)});
				end else begin
					dec_hi = 4'(v);
					dec_pend = 1'b1;
				end
			end
			if (eof && dec_fin == FIN_RUN && dec_phase == PH_RECORD) close_record();
		end
		if (eof) begin
			push_result(KIND_INPUT_END, 16'h0000, 8'h00, 8'h00);
			if (dec_fin == FIN_RUN) dec_fin = FIN_INPUT_END;
			dec_phase = PH_IDLE;
			dec_pend = 1'b0;
		end
	endtask

	task automatic add_char(input logic [7:0] c);
		char_item_t it;
		it.ch = c;
		it.last = 1'b0;
		it.drain = 1'b0;
		pending_chars.push_back(it);
	endtask

	task automatic mark_last();
		pending_chars[pending_chars.size() - 1].last = 1'b1;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i]);
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_char(hex_digit(b[7:4]));
		add_char(hex_digit(b[3:0]));
	endtask

	task automatic add_line_end();
		case ($urandom_range(0, 2))
			0: add_char(CH_CR);
			1: add_char(CH_LF);
			default: begin
				add_char(CH_CR);
				add_char(CH_LF);
			end
		endcase
	endtask

	// fill: 0 random data, 1 all zero, 2 all ones; last byte closes the sum unless bad_sum
	task automatic add_record(input logic [7:0] size, input logic [15:0] off,
			input logic [7:0] rtype, input int ndata, input int nextra,
			input logic [7:0] bad_sum, input int fill);
		logic [7:0] sum;
		logic [7:0] b;
		add_char(CH_COLON);
		sum = size + off[15:8] + off[7:0] + rtype;
		add_byte(size);
		add_byte(off[15:8]);
		add_byte(off[7:0]);
		add_byte(rtype);
		for (int i = 0; i < ndata + nextra; i++) begin
			b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
			sum = sum + b;
			add_byte(b);
		end
		add_byte(8'h00 - sum + bad_sum);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !char_taken) begin
			// item still waiting for ready
		end else if (pending_chars.size() > 0
				&& (!pending_chars[0].drain || expected_results.size() == 0)
				&& ((cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
				|| $urandom_range(0, 99) >= 8)) begin
			s_tvalid <= 1'b1;
			s_tdata <= pending_chars[0].ch;
			s_tlast <= pending_chars[0].last;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
				|| $urandom_range(0, 99) >= 8;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			char_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				predict_char(s_tdata, s_tlast);
				void'(pending_chars.pop_front());
			end
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.address = m_tdata[15:0];
				got.data_byte = m_tdata[23:16];
				got.record_type = m_tdata[31:24];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: kind %0d addr %h data %h type %h",
						$time, got.kind, got.address, got.data_byte, got.record_type);
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.address !== want.address
							|| got.data_byte !== want.data_byte
							|| got.record_type !== want.record_type) begin
						errors++;
						$display("%0t: expected kind %0d addr %h data %h type %h, got kind %0d addr %h data %h type %h",
							$time, want.kind, want.address, want.data_byte, want.record_type,
							got.kind, got.address, got.data_byte, got.record_type);
					end
				end
			end
		end
	end

	initial begin
		int next_addr;
		int big_at;
		int rec;
		int pick;
		int mark;
		int nextra;
		int fill;
		int k;
		logic [7:0] size;
		logic [7:0] sum;
		logic [7:0] c;
		stop_t stop_kind;

		decoder_reset();

		// empty lines, all-ones data in lower case, a skipped type with the top offset
		add_char(CH_LF);
		add_char(CH_CR);
		add_text(":01000000ff00");
		add_char(CH_LF);
		add_text(":00FFFFFF03");
		add_char(CH_CR);
		add_char(CH_LF);

		// mostly good data records in order, some skipped types and blank lines
		next_addr = 1;
		big_at = $urandom_range(1, 4);
		rec = 0;
		while (pending_chars.size() < 280) begin
			pick = $urandom_range(0, 99);
			mark = pending_chars.size();
			if (rec == big_at || pick < 70) begin
				size = (rec == big_at) ? 8'h40 : 8'($urandom_range(0, 16));
				nextra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
				fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
				add_record(size, 16'(next_addr), REC_DATA, int'(size), nextra, 8'h00, fill);
				next_addr += int'(size);
				add_line_end();
			end else if (pick < 90) begin
				add_record(8'($urandom_range(0, 8)), 16'($urandom), 8'($urandom_range(2, 255)),
					$urandom_range(0, 8), 0, 8'h00, 0);
				add_line_end();
			end else begin
				repeat ($urandom_range(1, 3)) add_line_end();
			end
			if (rec == 2) pending_chars[mark].drain = 1'b1;
			rec++;
		end

		stop_kind = stop_t'($urandom_range(0, 9));
		size = 8'($urandom_range(0, 8));
		case (stop_kind)
			STOP_NO_COLON: begin
				do c = 8'($urandom); while (c == CH_CR || c == CH_LF || c == CH_COLON);
				add_char(c);
			end
			STOP_BAD_DIGIT: begin
				add_char(CH_COLON);
				repeat ($urandom_range(0, 8)) add_char(hex_digit(4'($urandom)));
				do c = 8'($urandom); while (hex_value(c) >= 0 || c == CH_CR || c == CH_LF);
				add_char(c);
			end
			STOP_ODD_DIGITS: begin
				add_record(size, 16'(next_addr), REC_DATA, int'(size), 0, 8'h00, 0);
				add_char(hex_digit(4'($urandom)));
				add_line_end();
			end
			STOP_SHORT_HEADER: begin
				k = $urandom_range(1, 4);
				add_char(CH_COLON);
				sum = 8'h00;
				repeat (k - 1) begin
					c = 8'($urandom);
					sum = sum + c;
					add_byte(c);
				end
				add_byte(8'h00 - sum);
				add_line_end();
			end
			STOP_CHECKSUM: begin
				add_record(size, 16'(next_addr), REC_DATA, int'(size), 0,
					8'($urandom_range(1, 255)), 0);
				add_line_end();
			end
			STOP_OFFSET: begin
				add_record(size, $urandom_range(0, 1) ? 16'hFFFF
					: 16'(next_addr + $urandom_range(1, 100)),
					REC_DATA, int'(size), 0, 8'h00, 0);
				add_line_end();
			end
			STOP_LENGTH: begin
				size = 8'($urandom_range(1, 20));
				add_record(size, 16'(next_addr), REC_DATA, $urandom_range(0, int'(size) - 1),
					0, 8'h00, 0);
				add_line_end();
			end
			STOP_END_RECORD: begin
				size = 8'($urandom_range(0, 4));
				add_record(size, 16'($urandom), REC_EOF, int'(size), 0, 8'h00, 0);
				add_line_end();
			end
			STOP_EOF_OPEN: begin
				// last character of a good record also ends the input
				add_record(size, 16'(next_addr), REC_DATA, int'(size), 0, 8'h00, 0);
				mark_last();
			end
			default: begin
				// input ends right on a data byte, before the checksum
				size = 8'($urandom_range(2, 10));
				add_record(size, 16'(next_addr), REC_DATA, $urandom_range(1, int'(size) - 1),
					0, 8'h00, 0);
				void'(pending_chars.pop_back());
				void'(pending_chars.pop_back());
				mark_last();
			end
		endcase

		// after the stop only end-of-input marks give results
		repeat (60) begin
			add_char(8'($urandom));
			if ($urandom_range(0, 9) == 0) mark_last();
		end
		add_char(8'($urandom));
		mark_last();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("intel_hex_record_decoder regression: pass");
		end else begin
			$display("intel_hex_record_decoder regression: fail");
		end
		$finish;
	end

endmodule
